// ----- hw/rtl/mct_pkg.sv -----
// Shared types and constants for the masked code table.
package mct_pkg;

    localparam int POS_W   = 16;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 10;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
    localparam logic [ACT_W-1:0] ACT_ERASE  = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] code_value;
        logic [VAL_W-1:0] match_mask;
    } mct_req_t;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] found_index;
        logic [VAL_W-1:0] read_code;
    } mct_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic write_req;
        logic rd_pos;
        logic clr_cnt;
        logic scan_issue;
        logic scan_capture;
        logic sweep;
        logic load_out;
    } mct_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             in_range;
        logic             scan_done;
        logic             sweep_last;
        logic             rsp_busy;
    } mct_sts_t;

endpackage

// ----- hw/rtl/mct_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module mct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/mct_datapath.sv -----
// Datapath of the masked code table: request hold, code store, scan compare, response.
module mct_datapath #(
    parameter int ENTRIES    = 1024,
    parameter int CODE_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mct_pkg::mct_req_t req,
    input  logic              rsp_stall,
    output logic              rsp_valid,
    output mct_pkg::mct_rsp_t rsp,
    input  mct_pkg::mct_cmd_t cmd,
    output mct_pkg::mct_sts_t sts
);
    import mct_pkg::*;

    localparam int AW   = $clog2(ENTRIES);
    localparam int CNTW = AW + 1;
    localparam int XW   = (CODE_WIDTH > VAL_W) ? CODE_WIDTH : VAL_W;

    localparam logic [CODE_WIDTH-1:0] CODE_ONES = '1;
    localparam logic [XW-1:0]         ONES_X    = XW'(CODE_ONES);
    localparam logic [CNTW-1:0]       CNT_END   = CNTW'(ENTRIES);
    localparam logic [AW-1:0]         LAST_IDX  = AW'(ENTRIES - 1);
    localparam logic [POS_W:0]        POS_LIMIT = (POS_W + 1)'(ENTRIES);

    mct_req_t          req_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              cmp_valid_reg;
    logic [AW-1:0]     cmp_idx_reg;
    logic              found_reg;
    logic [AW-1:0]     found_idx_reg;
    logic              rsp_valid_reg;
    mct_rsp_t          rsp_reg;
    mct_rsp_t          rsp_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CODE_WIDTH-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CODE_WIDTH-1:0] ram_rdata;

    logic              in_range;
    logic [AW-1:0]     pos_addr;
    logic [XW-1:0]     code_x;
    logic [XW-1:0]     mask_x;
    logic [XW-1:0]     entry_x;
    logic              hit;

    assign in_range = {1'b0, req_reg.position} < POS_LIMIT;
    assign pos_addr = req_reg.position[AW-1:0];
    assign code_x   = XW'(req_reg.code_value) & ONES_X;
    assign mask_x   = XW'(req_reg.match_mask);
    assign entry_x  = XW'(ram_rdata);
    assign hit      = (entry_x & mask_x) == (code_x & mask_x);

    always_comb
    begin
        ram_we    = cmd.sweep | cmd.write_req;
        ram_waddr = cmd.sweep ? cnt_reg[AW-1:0] : pos_addr;
        ram_wdata = cmd.sweep ? CODE_ONES : code_x[CODE_WIDTH-1:0];
        ram_re    = cmd.scan_issue | cmd.rd_pos;
        ram_raddr = cmd.scan_issue ? cnt_reg[AW-1:0] : pos_addr;
    end

    mct_ram #(
        .WIDTH (CODE_WIDTH),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.status      = 1'b1;
        unique case (req_reg.action)
            ACT_WRITE:
            begin
                rsp_next.status = !in_range;
            end
            ACT_READ:
            begin
                rsp_next.status    = !in_range;
                rsp_next.read_code = in_range ? VAL_W'(entry_x) : VAL_W'(ONES_X);
            end
            ACT_SEARCH:
            begin
                rsp_next.status      = !found_reg;
                rsp_next.found_index = found_reg ? IDX_W'(found_idx_reg) : '0;
            end
            ACT_ERASE:
            begin
                rsp_next.status = 1'b0;
            end
            default:
            begin
                rsp_next.status = 1'b1;
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.scan_issue)
        begin
            cmp_idx_reg <= cnt_reg[AW-1:0];
        end
        if (cmd.scan_capture)
        begin
            found_idx_reg <= cmp_idx_reg;
        end
        if (cmd.load_out)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan_issue || cmd.sweep)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            cmp_valid_reg <= cmd.scan_issue;
            if (cmd.clr_cnt)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.scan_capture)
            begin
                found_reg <= hit;
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.action     = req_reg.action;
        sts.in_range   = in_range;
        sts.scan_done  = cmp_valid_reg && (hit || (cmp_idx_reg == LAST_IDX));
        sts.sweep_last = cnt_reg[AW-1:0] == LAST_IDX;
        sts.rsp_busy   = rsp_valid_reg && rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |-> (cnt_reg < CNT_END))
        else $error("scan read issued past the last entry");

    a_rsp_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.load_out))
        else $error("response raised without a load");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rsp_valid_reg) && $past(rsp_stall)) |-> (rsp_valid_reg && $stable(rsp_reg)))
        else $error("stalled response changed");
`endif

endmodule

// ----- hw/rtl/mct_ctrl.sv -----
// Controller of the masked code table: sequences clearing, requests and responses.
module mct_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mct_pkg::mct_sts_t sts,
    output mct_pkg::mct_cmd_t cmd
);
    import mct_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_READ_WAIT,
        ST_SCAN,
        ST_ERASE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_START;
                end
            end
            ST_START:
            begin
                unique case (sts.action)
                    ACT_WRITE:
                    begin
                        cmd.write_req = sts.in_range;
                        state_next    = ST_DONE;
                    end
                    ACT_READ:
                    begin
                        cmd.rd_pos = sts.in_range;
                        state_next = sts.in_range ? ST_READ_WAIT : ST_DONE;
                    end
                    ACT_SEARCH:
                    begin
                        cmd.clr_cnt = 1'b1;
                        state_next  = ST_SCAN;
                    end
                    ACT_ERASE:
                    begin
                        cmd.clr_cnt = 1'b1;
                        state_next  = ST_ERASE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                // stop issuing once the first hit or the last entry is compared
                if (sts.scan_done)
                begin
                    cmd.scan_capture = 1'b1;
                    state_next       = ST_DONE;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                end
            end
            ST_ERASE:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sts.rsp_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = state_reg != ST_IDLE;

`ifndef NO_ASSERTIONS
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_out && sts.rsp_busy))
        else $error("response loaded over a stalled one");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_req && cmd.sweep))
        else $error("write port driven twice");

    a_accept_then_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_START))
        else $error("accepted request not started");
`endif

endmodule

// ----- hw/rtl/masked_code_table_core.sv -----
// Masked code table top level: controller plus datapath over one code store RAM.
// A search compares one stored entry per cycle from the RAM read port, stopping at the first
// hit or after the last of the ENTRIES entries; an erase sweeps every entry.
// One request is handled at a time; a new one is accepted once the previous response is loaded.
// After reset the store is cleared to all ones by a sweep over every entry with req_stall high.
module masked_code_table_core #(
    parameter int ENTRIES    = 1024,
    parameter int CODE_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mct_pkg::mct_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output mct_pkg::mct_rsp_t rsp
);
    import mct_pkg::*;

    mct_cmd_t cmd;
    mct_sts_t sts;

    mct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mct_datapath #(
        .ENTRIES    (ENTRIES),
        .CODE_WIDTH (CODE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
